// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the ARP cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/acp_pkg.sv -----
// Shared types and constants of the ARP cache.
`timescale 1ns / 1ps
package acp_pkg;

   localparam int unsigned ENTRIES_DEF = 16;
   localparam int unsigned IP_W        = 32;
   localparam int unsigned MAC_W       = 48;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_ADD    = 1'b1;

   typedef struct packed {
      logic             active;
      logic             found;
      logic [MAC_W-1:0] mac;
   } acp_tok_type;

   typedef struct packed {
      logic add;
      logic full;
   } acp_ctl_type;

endpackage

// ----- rtl/core/acp_cell.sv -----
// One table slot: stored pair, valid mark and one stage of the lookup chain.
`timescale 1ns / 1ps
module acp_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  acp_pkg::acp_ctl_type      ctl,
   input  logic [acp_pkg::IP_W-1:0]  new_ip,
   input  logic [acp_pkg::MAC_W-1:0] new_mac,
   input  logic [acp_pkg::IP_W-1:0]  up_ip,
   input  logic [acp_pkg::MAC_W-1:0] up_mac,
   input  logic                      up_valid,
   input  logic                      prev_valid,
   input  logic [acp_pkg::IP_W-1:0]  key,
   input  acp_pkg::acp_tok_type      tok_i,
   output acp_pkg::acp_tok_type      tok_o,
   output logic [acp_pkg::IP_W-1:0]  ip_o,
   output logic [acp_pkg::MAC_W-1:0] mac_o,
   output logic                      valid_o
);

   logic [acp_pkg::IP_W-1:0]  ip_ff, ip_in;
   logic [acp_pkg::MAC_W-1:0] mac_ff, mac_in;
   logic                      valid_ff, valid_in;
   acp_pkg::acp_tok_type      tok_ff, tok_in;
   logic                      hit;

   always_comb begin
      ip_in    = ip_ff;
      mac_in   = mac_ff;
      valid_in = valid_ff;
      if (ctl.add && ctl.full) begin
         ip_in    = up_ip;
         mac_in   = up_mac;
         valid_in = up_valid;
      end else if (ctl.add && !valid_ff && prev_valid) begin
         ip_in    = new_ip;
         mac_in   = new_mac;
         valid_in = 1'b1;
      end
   end

   assign hit = valid_ff && (ip_ff == key);

   always_comb begin
      tok_in.active = tok_i.active;
      tok_in.found  = tok_i.found | hit;
      if (tok_i.found) begin
         tok_in.mac = tok_i.mac;
      end else if (hit) begin
         tok_in.mac = mac_ff;
      end else begin
         tok_in.mac = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         tok_ff.active <= tok_in.active;
      end
      ip_ff        <= ip_in;
      mac_ff       <= mac_in;
      tok_ff.found <= tok_in.found;
      tok_ff.mac   <= tok_in.mac;
   end

   assign tok_o   = tok_ff;
   assign ip_o    = ip_ff;
   assign mac_o   = mac_ff;
   assign valid_o = valid_ff;

endmodule

// ----- rtl/core/arp_cache_fifo_replace.sv -----
// Top level of the fully associative ARP cache with FIFO replacement.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser kind, tdata ip_address, mac_address
//  rsp     | out | rsp_tvalid/rsp_tready | tuser found, tdata mac_result
//
//  An add updates the slots in the cycle after the beat.
//  A lookup walks the row of cells, one cell per cycle, so the time from
//  beat to the next req_tready grows with the row length and with any rsp stall.
//  A lookup is accepted while an earlier result still waits on rsp.
//  Reset clears all valid marks and any lookup in flight; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module arp_cache_fifo_replace #(
   parameter int unsigned ENTRIES = acp_pkg::ENTRIES_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [acp_pkg::IP_W+acp_pkg::MAC_W-1:0]       req_tdata,  // ip_address, mac_address
   input  logic                                          req_tuser,  // kind
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [acp_pkg::MAC_W-1:0]                     rsp_tdata,  // mac_result
   output logic                                          rsp_tuser   // found
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DONE   = 3'b100
   } acp_state_type;

   acp_state_type state_ff, state_in;

   logic [acp_pkg::IP_W-1:0]  req_ip;
   logic [acp_pkg::MAC_W-1:0] req_mac;
   logic                      req_beat, add_beat, look_beat;

   logic [acp_pkg::IP_W-1:0]  key_ff, key_in;
   logic                      start_ff, start_in;
   logic                      hold_found_ff, hold_found_in;
   logic [acp_pkg::MAC_W-1:0] hold_mac_ff, hold_mac_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [acp_pkg::MAC_W-1:0] rsp_mac_ff, rsp_mac_in;
   logic                      rsp_load;

   acp_pkg::acp_ctl_type      ctl;
   acp_pkg::acp_tok_type      tok_head;
   acp_pkg::acp_tok_type      tok [ENTRIES];
   logic [acp_pkg::IP_W-1:0]  cell_ip  [ENTRIES];
   logic [acp_pkg::MAC_W-1:0] cell_mac [ENTRIES];
   logic [ENTRIES-1:0]        cell_valid;
   logic [ENTRIES-1:0]        tok_act;

   assign req_ip    = req_tdata[acp_pkg::IP_W-1:0];
   assign req_mac   = req_tdata[acp_pkg::IP_W+acp_pkg::MAC_W-1:acp_pkg::IP_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat  = req_tvalid && req_tready;
   assign add_beat  = req_beat && (req_tuser == acp_pkg::KIND_ADD);
   assign look_beat = req_beat && (req_tuser == acp_pkg::KIND_LOOKUP);

   assign ctl.add  = add_beat;
   assign ctl.full = cell_valid[ENTRIES-1];

   assign tok_head.active = start_ff;
   assign tok_head.found  = 1'b0;
   assign tok_head.mac    = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [acp_pkg::IP_W-1:0]  up_ip;
      logic [acp_pkg::MAC_W-1:0] up_mac;
      logic                      up_valid;
      logic                      prev_valid;
      acp_pkg::acp_tok_type      tok_i;

      if (i == ENTRIES - 1) begin : g_last
         assign up_ip    = req_ip;
         assign up_mac   = req_mac;
         assign up_valid = 1'b1;
      end else begin : g_mid
         assign up_ip    = cell_ip[i+1];
         assign up_mac   = cell_mac[i+1];
         assign up_valid = cell_valid[i+1];
      end

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
         assign tok_i      = tok_head;
      end else begin : g_rest
         assign prev_valid = cell_valid[i-1];
         assign tok_i      = tok[i-1];
      end

      acp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_ip     (req_ip),
         .new_mac    (req_mac),
         .up_ip      (up_ip),
         .up_mac     (up_mac),
         .up_valid   (up_valid),
         .prev_valid (prev_valid),
         .key        (key_ff),
         .tok_i      (tok_i),
         .tok_o      (tok[i]),
         .ip_o       (cell_ip[i]),
         .mac_o      (cell_mac[i]),
         .valid_o    (cell_valid[i])
      );

      assign tok_act[i] = tok[i].active;
   end

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      start_in      = 1'b0;
      hold_found_in = hold_found_ff;
      hold_mac_in   = hold_mac_ff;
      case (state_ff)
         ST_IDLE: begin
            if (look_beat) begin
               key_in   = req_ip;
               start_in = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok[ENTRIES-1].active) begin
               hold_found_in = tok[ENTRIES-1].found;
               hold_mac_in   = tok[ENTRIES-1].mac;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_mac_in   = rsp_mac_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hold_found_ff;
         rsp_mac_in   = hold_mac_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      hold_found_ff <= hold_found_in;
      hold_mac_ff   <= hold_mac_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_mac_ff    <= rsp_mac_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_mac_ff;

   `ASSERT_HOLDS(a_valid_packed, clock, reset, (cell_valid & ~{cell_valid[ENTRIES-2:0], 1'b1}) == '0)
   `ASSERT_HOLDS(a_one_token, clock, reset, $onehot0({tok_act, start_ff}))
   `ASSERT_IMPLIES(a_idle_no_token, clock, reset, req_tready, (tok_act == '0) && !start_ff)
   `ASSERT_NEXT(a_add_grows, clock, reset, add_beat && !cell_valid[ENTRIES-1], $countones(cell_valid) == $countones($past(cell_valid)) + 1)

endmodule
